/* rtl/core/prfa_pkg.sv */
// Shared types and constants for the page range first-fit allocator.
// Used by prfa_cell, prfa_chain and page_range_first_fit_allocator.
// No dependencies.
package prfa_pkg;

  // Sizing
  localparam int MAX_RANGES = 128;
  localparam int PAGE_BYTES = 4096;       // power of two
  localparam int ADDR_W     = 64;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int FREE_W     = 8;
  localparam int PADDR_W    = 4;

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0] BASE_RST  = '0;
  localparam logic [ADDR_W-1:0] SIZE_RST  = 64'd268435456;

  // Request codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Register select (paddr bit 3)
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_NOFIT     = 3'd3,
    ST_UNALIGNED = 3'd4,
    ST_OUTSIDE   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_RELOAD,
    S_INIT,
    S_IDLE,
    S_CALC,
    S_CHECK,
    S_PASS,
    S_FIN
  } fsm_t;

  // One free range
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } range_t;

  // Controls into the cell chain
  typedef struct packed {
    logic clr;
    logic pop;
    logic push;
  } chain_ctl_t;

  // Status out of the cell chain
  typedef struct packed {
    logic head_v;
    logic tail_v;
  } chain_sts_t;

endpackage

/* rtl/core/prfa_cell.sv */
// One storage cell of the free-range chain: holds one range and a valid bit.
// Takes from the upper neighbor when empty, hands down when the lower slot frees.
// Depends on prfa_pkg.
module prfa_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  logic            up_v,
  input  prfa_pkg::range_t up_d,
  input  logic            dn_free,
  output logic            v,
  output prfa_pkg::range_t d
);
  import prfa_pkg::*;

  logic   v_r;
  logic   v_nxt;
  range_t d_r;
  logic   take;
  logic   leave;

  // Move decisions use registered neighbor state; the end cells use push and pop
  assign take  = !v_r && up_v;
  assign leave = v_r && dn_free;

  always_comb begin
    v_nxt = v_r;
    if (clr) begin
      v_nxt = 1'b0;
    end else if (take) begin
      v_nxt = 1'b1;
    end else if (leave) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      d_r <= up_d;
    end
  end

  assign v = v_r;
  assign d = d_r;

endmodule

/* rtl/core/prfa_chain.sv */
// Row of MAX_RANGES cells forming a self-compacting FIFO of free ranges.
// Writes enter at the tail cell, reads leave from the head cell.
// Depends on prfa_pkg and prfa_cell.
module prfa_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  prfa_pkg::chain_ctl_t ctl,
  input  prfa_pkg::range_t     push_d,
  output prfa_pkg::range_t     head_d,
  output prfa_pkg::chain_sts_t sts
);
  import prfa_pkg::*;

  logic   cell_v [MAX_RANGES];
  range_t cell_d [MAX_RANGES];

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    logic   up_v;
    range_t up_d;
    logic   dn_free;

    // Upper neighbor: the write port for the tail cell
    if (i == MAX_RANGES - 1) begin : g_tail
      assign up_v = ctl.push;
      assign up_d = push_d;
    end else begin : g_mid
      assign up_v = cell_v[i+1];
      assign up_d = cell_d[i+1];
    end

    // Lower slot frees: the read for the head cell
    if (i == 0) begin : g_head
      assign dn_free = ctl.pop;
    end else begin : g_low
      assign dn_free = !cell_v[i-1];
    end

    prfa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (ctl.clr),
      .up_v    (up_v),
      .up_d    (up_d),
      .dn_free (dn_free),
      .v       (cell_v[i]),
      .d       (cell_d[i])
    );
  end

  assign head_d     = cell_d[0];
  assign sts.head_v = cell_v[0];
  assign sts.tail_v = cell_v[MAX_RANGES-1];

endmodule

/* rtl/core/page_range_first_fit_allocator.sv */
// Top level of the page range first-fit allocator: APB registers, request
// checks, and the merge unit at the head of the free-range chain.
// Depends on prfa_pkg and prfa_chain.
//
// The free list lives in a chain of MAX_RANGES cells that acts as a FIFO; a
// request that reaches the list streams every held range once out of the head
// cell, through the carve/merge unit, and back in at the tail. Requests are
// handled one at a time. A request rejected by its checks (zero length,
// unaligned, rounding overflow, outside region, list full) goes from the
// check state to the result stage without walking the list, and the next
// request is taken once its result is loaded into the result register. An
// allocate or free that walks the list reads each held range from the head
// cell and then passes it through the unit; its first read may also wait while
// ranges written back by the previous request descend the chain. A range is
// written back only into an empty tail cell, so when the list nearly fills the
// chain each slot freed at the head must climb to the tail first, which slows
// the walk. Ranges move along the chain one cell per cycle. After reset and
// after any register write the list is reloaded with the whole region in the
// reload and init states, during which no request is taken.
// Registers: region_base at byte 0x0, region_size at 0x8 (64-bit data).
module page_range_first_fit_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [prfa_pkg::ADDR_W-1:0]   in_start_addr,
  input  logic [prfa_pkg::ADDR_W-1:0]   in_length_bytes,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prfa_pkg::ADDR_W-1:0]   out_alloc_addr,
  output logic [2:0]                    out_status,
  output logic [prfa_pkg::FREE_W-1:0]   out_free_ranges,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [prfa_pkg::ADDR_W-1:0]   pwdata,
  output logic [prfa_pkg::ADDR_W-1:0]   prdata,
  output logic                          pready
);
  import prfa_pkg::*;

  // ---------------- declarations ----------------
  fsm_t              state_r, state_nxt;
  logic [ADDR_W-1:0] base_r, size_r;
  logic [ADDR_W-1:0] b_eff_r, e_eff_r, init_len_r;
  logic              init_v_r;
  logic [CNT_W-1:0]  count_r, rem_r, new_cnt_r;

  logic              mode_r;
  logic [ADDR_W-1:0] start_r, len_r, aligned_r, room_r, n_end_r;
  logic              ovf_r, lo_r, hi_r;
  status_t           st_r, chk_st;
  logic [ADDR_W-1:0] addr_r;

  logic              hv_r, cv_r, ins_r, found_r;
  range_t            hold_r;
  logic [ADDR_W-1:0] hold_e_r, cur_s_r, cur_e_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_status_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              cfg_wr;
  logic [ADDR_W-1:0] b_eff, sz_eff;
  logic [ADDR_W:0]   rsum, rnd;

  chain_ctl_t        ch_ctl;
  chain_sts_t        ch_sts;
  range_t            push_d, head_d, cur_d, carved;

  logic              rem_zero, use_n, src_v, touch, fits, drop, pass_done, out_free;
  logic [ADDR_W-1:0] src_s, src_e, new_e;
  logic              cons, cons_hold, cons_n, cur_load, cur_merge, flush, fit_take;

  // ---------------- register port ----------------
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_SIZE) ? size_r : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RST;
      size_r <= SIZE_RST;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_BASE) begin
        base_r <= pwdata;
      end else begin
        size_r <= pwdata;
      end
    end
  end

  // ---------------- region arithmetic ----------------
  assign b_eff  = base_r & ~PAGE_MASK;
  assign sz_eff = size_r & ~PAGE_MASK;
  assign rsum   = {1'b0, b_eff} + {1'b0, sz_eff};

  // page round-up; carry out means overflow
  assign rnd = {1'b0, len_r} + {1'b0, PAGE_MASK};

  // ---------------- request checks ----------------
  always_comb begin
    chk_st = ST_OK;
    if (mode_r == MODE_FREE) begin
      if (start_r == '0 || len_r == '0) begin
        chk_st = ST_ZERO;
      end else if ((start_r & PAGE_MASK) != '0) begin
        chk_st = ST_UNALIGNED;
      end else if (ovf_r) begin
        chk_st = ST_OVERFLOW;
      end else if (lo_r || hi_r || (aligned_r > room_r)) begin
        chk_st = ST_OUTSIDE;
      end else if (count_r >= CNT_W'(MAX_RANGES)) begin
        chk_st = ST_FULL;
      end
    end else begin
      if (len_r == '0) begin
        chk_st = ST_ZERO;
      end else if (ovf_r) begin
        chk_st = ST_OVERFLOW;
      end
    end
  end

  // ---------------- merge / carve unit ----------------
  assign rem_zero = (rem_r == '0);
  // new range goes ahead of the first held range whose start is not below it
  assign use_n    = (mode_r == MODE_FREE) && ins_r &&
                    (hv_r ? (start_r <= hold_r.start) : rem_zero);
  assign src_v    = use_n || hv_r;
  assign src_s    = use_n ? start_r : hold_r.start;
  assign src_e    = use_n ? n_end_r : hold_e_r;
  assign touch    = (cur_e_r >= src_s);
  assign new_e    = (src_e > cur_e_r) ? src_e : cur_e_r;
  assign cur_d    = '{start: cur_s_r, len: cur_e_r - cur_s_r};

  assign fits         = !found_r && (hold_r.len >= aligned_r);
  assign drop         = (hold_r.len == aligned_r);
  assign carved.start = hold_r.start + aligned_r;
  assign carved.len   = hold_r.len - aligned_r;

  assign pass_done = (mode_r == MODE_FREE) ? (rem_zero && !hv_r && !ins_r && !cv_r)
                                           : (rem_zero && !hv_r);
  assign out_free  = !out_valid_r || out_ready;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RELOAD: state_nxt = S_INIT;
      S_INIT:   state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) begin
        state_nxt = S_CALC;
      end
      S_CALC:   state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (chk_st == ST_OK) ? S_PASS : S_FIN;
      S_PASS:   if (pass_done) begin
        state_nxt = S_FIN;
      end
      S_FIN:    if (out_free) begin
        state_nxt = S_IDLE;
      end
      default:  state_nxt = S_RELOAD;
    endcase
    if (cfg_wr) begin
      state_nxt = S_RELOAD;
    end
  end

  // ---------------- state outputs ----------------
  always_comb begin
    in_ready   = 1'b0;
    ch_ctl     = '0;
    push_d     = cur_d;
    cons       = 1'b0;
    cons_hold  = 1'b0;
    cons_n     = 1'b0;
    cur_load   = 1'b0;
    cur_merge  = 1'b0;
    flush      = 1'b0;
    fit_take   = 1'b0;
    unique case (state_r)
      S_RELOAD: ch_ctl.clr = 1'b1;
      S_INIT: begin
        ch_ctl.push = init_v_r;
        push_d      = '{start: b_eff_r, len: init_len_r};
      end
      S_IDLE: in_ready = 1'b1;
      S_PASS: begin
        ch_ctl.pop = !rem_zero && ch_sts.head_v && !hv_r;
        if (mode_r == MODE_FREE) begin
          if (src_v) begin
            if (!cv_r) begin
              cons     = 1'b1;
              cur_load = 1'b1;
            end else if (touch) begin
              cons      = 1'b1;
              cur_merge = 1'b1;
            end else if (!ch_sts.tail_v) begin
              // emit finished range, start a new one
              cons        = 1'b1;
              cur_load    = 1'b1;
              ch_ctl.push = 1'b1;
            end
          end else if (rem_zero && !ins_r && cv_r && !ch_sts.tail_v) begin
            flush       = 1'b1;
            ch_ctl.push = 1'b1;
          end
          cons_hold = cons && !use_n;
          cons_n    = cons && use_n;
        end else if (hv_r) begin
          if (fits && drop) begin
            cons_hold = 1'b1;
            fit_take  = 1'b1;
          end else if (!ch_sts.tail_v) begin
            cons_hold   = 1'b1;
            fit_take    = fits;
            ch_ctl.push = 1'b1;
            push_d      = fits ? carved : hold_r;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RELOAD;
      count_r     <= '0;
      hv_r        <= 1'b0;
      cv_r        <= 1'b0;
      ins_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result register: load from the result stage, else drain on transfer
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: count_r <= CNT_W'(init_v_r);
        S_CHECK: begin
          hv_r    <= 1'b0;
          cv_r    <= 1'b0;
          found_r <= 1'b0;
          ins_r   <= (chk_st == ST_OK) && (mode_r == MODE_FREE);
        end
        S_PASS: begin
          if (ch_ctl.pop) begin
            hv_r <= 1'b1;
          end else if (cons_hold) begin
            hv_r <= 1'b0;
          end
          if (cons_n) begin
            ins_r <= 1'b0;
          end
          if (cur_load) begin
            cv_r <= 1'b1;
          end else if (flush) begin
            cv_r <= 1'b0;
          end
          if (fit_take) begin
            found_r <= 1'b1;
          end
          if (pass_done) begin
            count_r <= new_cnt_r;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_RELOAD: begin
        b_eff_r    <= b_eff;
        e_eff_r    <= rsum[ADDR_W] ? '1 : rsum[ADDR_W-1:0];
        init_len_r <= rsum[ADDR_W] ? ~b_eff : sz_eff;
        init_v_r   <= (sz_eff != '0);
      end
      S_IDLE: begin
        mode_r  <= in_mode;
        start_r <= in_start_addr;
        len_r   <= in_length_bytes;
      end
      S_CALC: begin
        aligned_r <= rnd[ADDR_W-1:0] & ~PAGE_MASK;
        ovf_r     <= rnd[ADDR_W];
        lo_r      <= (start_r < b_eff_r);
        hi_r      <= (start_r >= e_eff_r);
        room_r    <= e_eff_r - start_r;
      end
      S_CHECK: begin
        n_end_r   <= start_r + aligned_r;
        st_r      <= chk_st;
        addr_r    <= '0;
        rem_r     <= count_r;
        new_cnt_r <= '0;
      end
      S_PASS: begin
        if (ch_ctl.pop) begin
          rem_r    <= rem_r - 1'b1;
          hold_r   <= head_d;
          hold_e_r <= head_d.start + head_d.len;
        end
        if (cur_load) begin
          cur_s_r <= src_s;
          cur_e_r <= src_e;
        end else if (cur_merge) begin
          cur_e_r <= new_e;
        end
        if (ch_ctl.push) begin
          new_cnt_r <= new_cnt_r + 1'b1;
        end
        if (fit_take) begin
          addr_r <= hold_r.start;
        end
        if (pass_done && mode_r == MODE_ALLOC) begin
          st_r <= found_r ? ST_OK : ST_NOFIT;
        end
      end
      S_FIN: if (out_free) begin
        out_addr_r   <= addr_r;
        out_status_r <= st_r;
        out_cnt_r    <= count_r;
      end
      default: ;
    endcase
  end

  // ---------------- free-range chain ----------------
  prfa_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ch_ctl),
    .push_d (push_d),
    .head_d (head_d),
    .sts    (ch_sts)
  );

  assign out_valid       = out_valid_r;
  assign out_alloc_addr  = out_addr_r;
  assign out_status      = out_status_r;
  assign out_free_ranges = FREE_W'(out_cnt_r);

  // ---------------- assertions ----------------
  a_push_tail_free: assert property (@(posedge clk) disable iff (!rst_n)
    ch_ctl.push |-> !ch_sts.tail_v)
    else $error("write into occupied tail cell");

  a_pop_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    ch_ctl.pop |-> (state_r == S_PASS && rem_r != '0 && !hv_r))
    else $error("read from chain outside a list walk");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("range count above capacity");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!hv_r && !cv_r && !ins_r))
    else $error("merge unit holds a range while idle");

  a_fin_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS && pass_done && !cfg_wr) |=> (state_r == S_FIN))
    else $error("list walk did not end in result stage");

endmodule

/* tb/sv/tb_page_range_first_fit_allocator.sv */
// Self-checking testbench for the page range first-fit allocator.
// Drives requests and APB writes, predicts every result in a local free-list
// model and compares field by field. Depends on prfa_pkg and the RTL.
`timescale 1ns / 100ps

module tb_page_range_first_fit_allocator;
  import prfa_pkg::*;

  localparam int          LIST_DEPTH = 128;
  localparam logic [63:0] PG         = 64'd4096;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [3:0]  ADDR_BASE  = 4'h0;
  localparam logic [3:0]  ADDR_SIZE  = 4'h8;
  localparam longint      CYCLE_LIMIT = 100_000_000;

  typedef struct packed {
    logic [63:0] addr;
    logic [2:0]  status;
    logic [7:0]  count;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_mode = 1'b0;
  logic [63:0] in_start_addr = '0, in_length_bytes = '0;
  logic in_ready;
  logic out_valid, out_ready = 1'b0;
  logic [63:0] out_alloc_addr;
  logic [2:0]  out_status;
  logic [7:0]  out_free_ranges;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0, prdata;
  logic pready;

  page_range_first_fit_allocator dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_mode, .in_start_addr, .in_length_bytes,
    .out_valid, .out_ready, .out_alloc_addr, .out_status, .out_free_ranges,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Free-list predictor state
  logic [63:0] cfg_base, cfg_size;
  logic [63:0] fl_start [LIST_DEPTH+1];
  logic [63:0] fl_len   [LIST_DEPTH+1];
  int          fl_count;

  alloc_result_t pending_results [$];
  int  errors = 0;
  int  results_seen = 0;
  int  n_ok = 0, n_rej = 0;
  longint cycles = 0;
  bit  hold_off = 1'b0;
  bit  long_stall = 1'b0;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  function automatic logic [63:0] region_lo();
    return cfg_base & ~(PG - 1);
  endfunction

  function automatic logic [63:0] region_hi();
    return sat_add(region_lo(), cfg_size & ~(PG - 1));
  endfunction

  // Rebuild the list with the whole region
  function automatic void reload_list();
    logic [63:0] b, e;
    b = region_lo();
    e = region_hi();
    fl_count = 0;
    if (e > b) begin
      fl_start[0] = b;
      fl_len[0] = e - b;
      fl_count = 1;
    end
  endfunction

  function automatic bit page_roundup(logic [63:0] len, output logic [63:0] res);
    logic [63:0] rem;
    rem = len & (PG - 1);
    res = len;
    if (rem == 0) return 1'b1;
    if (len > ALL_ONES - (PG - rem)) return 1'b0;
    res = len + (PG - rem);
    return 1'b1;
  endfunction

  function automatic void drop_entry(int idx);
    for (int j = idx; j + 1 < fl_count; j++) begin
      fl_start[j] = fl_start[j+1];
      fl_len[j] = fl_len[j+1];
    end
    fl_count--;
  endfunction

  // Compute the outcome of one request and update the list
  function automatic alloc_result_t predict_request(logic mode, logic [63:0] sa,
                                                    logic [63:0] len);
    alloc_result_t r;
    logic [63:0] pages, b, e, ae, be;
    int pos, i;
    r = '0;
    r.status = ST_OK;
    if (mode == MODE_ALLOC) begin
      if (len == 0) r.status = ST_ZERO;
      else if (!page_roundup(len, pages)) r.status = ST_OVERFLOW;
      else begin
        r.status = ST_NOFIT;
        for (i = 0; i < fl_count; i++) begin
          if (fl_len[i] >= pages) begin
            r.addr = fl_start[i];
            fl_start[i] += pages;
            fl_len[i] -= pages;
            if (fl_len[i] == 0) drop_entry(i);
            r.status = ST_OK;
            break;
          end
        end
      end
    end else begin
      b = region_lo();
      e = region_hi();
      if (sa == 0 || len == 0) r.status = ST_ZERO;
      else if ((sa & (PG - 1)) != 0) r.status = ST_UNALIGNED;
      else if (!page_roundup(len, pages)) r.status = ST_OVERFLOW;
      else if (sa < b || sa >= e || pages > e - sa) r.status = ST_OUTSIDE;
      else if (fl_count >= LIST_DEPTH) r.status = ST_FULL;
      else begin
        pos = 0;
        while (pos < fl_count && fl_start[pos] < sa) pos++;
        for (i = fl_count; i > pos; i--) begin
          fl_start[i] = fl_start[i-1];
          fl_len[i] = fl_len[i-1];
        end
        fl_start[pos] = sa;
        fl_len[pos] = pages;
        fl_count++;
        // merge touching or overlapping neighbors
        i = 0;
        while (i + 1 < fl_count) begin
          ae = sat_add(fl_start[i], fl_len[i]);
          be = sat_add(fl_start[i+1], fl_len[i+1]);
          if (ae >= fl_start[i+1]) begin
            fl_len[i] = ((ae > be) ? ae : be) - fl_start[i];
            drop_entry(i + 1);
          end else i++;
        end
      end
    end
    r.count = fl_count[7:0];
    return r;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("** page_range_first_fit_allocator: FAILED **");
      $finish;
    end
  end

  // Result receiver with random back-pressure
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        continue;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && !hold_off);
      out_ready <= 1'b0;
    end
  end

  // Long receiver stall, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall) begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
        long_stall = 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer addr=%h status=%0d count=%0d", $time,
                 out_alloc_addr, out_status, out_free_ranges);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_alloc_addr !== exp_r.addr) begin
          errors++;
          $display("%0t: alloc_addr expected %h actual %h", $time, exp_r.addr,
                   out_alloc_addr);
        end
        if (out_status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_status);
        end
        if (out_free_ranges !== exp_r.count) begin
          errors++;
          $display("%0t: free_ranges expected %0d actual %0d", $time, exp_r.count,
                   out_free_ranges);
        end
      end
    end
  end

  // Send one request; predicts at acceptance
  task automatic send_request(logic mode, logic [63:0] sa, logic [63:0] len,
                              bit no_gap = 0);
    alloc_result_t r;
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
    repeat (gap) @(posedge clk);
    // previous transfer ended in this time step: let valid drop first
    if (in_valid) @(posedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_start_addr <= sa;
    in_length_bytes <= len;
    do @(posedge clk); while (!in_ready);
    r = predict_request(mode, sa, len);
    if (r.status == ST_OK) n_ok++; else n_rej++;
    pending_results.push_back(r);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic apb_write(logic [3:0] a, logic [63:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == ADDR_BASE) cfg_base = d; else cfg_size = d;
    reload_list();
    repeat (4) @(posedge clk);
  endtask

  task automatic set_region(logic [63:0] b, logic [63:0] s);
    wait_idle();
    apb_write(ADDR_BASE, b);
    apb_write(ADDR_SIZE, s);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Directed corner cases on the reset region
  task automatic test_directed();
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 0, 64'h1000);
    send_request(MODE_FREE, 64'h1000, 0);
    send_request(MODE_FREE, 64'h1001, 64'h1000);
    send_request(MODE_ALLOC, 0, ALL_ONES);
    send_request(MODE_FREE, 64'h2000, ALL_ONES);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_ALLOC, 0, 64'h3001);
    send_request(MODE_ALLOC, 0, 64'h1000_0000);
    send_request(MODE_FREE, 64'h1000, 64'h1000);
    send_request(MODE_FREE, 64'h1000, 64'h2000);
    send_request(MODE_FREE, 64'h1000_0000, 64'h1000);
    send_request(MODE_FREE, 64'h0FFF_F000, 64'h2000);
    send_request(MODE_FREE, ALL_ONES & ~(PG - 1), 64'h1000);
    send_request(MODE_ALLOC, 0, 64'h0FFF_0000);
    send_request(MODE_ALLOC, 0, 64'h8000);
    send_request(MODE_ALLOC, 0, ALL_ONES - 64'hFFF);
  endtask

  // Region that ends at the top of the address space
  task automatic test_saturated_region();
    set_region(ALL_ONES - 64'hF_FFFF, ALL_ONES);
    send_request(MODE_ALLOC, 0, 64'h1000);
    send_request(MODE_ALLOC, 0, 64'h2_0000);
    send_request(MODE_FREE, ALL_ONES - 64'hF_FFFF & ~(PG - 1), 64'h1000);
    send_request(MODE_FREE, ALL_ONES & ~(PG - 1), 64'h1000);
    send_request(MODE_ALLOC, 0, 64'hF_F000);
    // empty region: size below one page
    set_region(64'h5000, 64'hFFF);
    send_request(MODE_ALLOC, 0, 64'h1000);
    send_request(MODE_FREE, 64'h5000, 64'h1000);
  endtask

  // Fragment the list to its limit to reach the full status
  task automatic test_list_full();
    set_region(64'h10_0000, 64'h40_0000);
    send_request(MODE_ALLOC, 0, 64'h40_0000);
    for (int i = 0; i < LIST_DEPTH + 4; i++)
      send_request(MODE_FREE, 64'h10_0000 + i * 64'h2000, 64'h1000, 1);
    send_request(MODE_FREE, 64'h10_1000, 64'h1000);
    send_request(MODE_ALLOC, 0, 64'h1000);
    send_request(MODE_FREE, 64'h10_1000, 64'h1000);
  endtask

  // Receiver stalls long while requests keep coming
  task automatic test_backpressure();
    set_region(64'h40_0000, 64'h20_0000);
    long_stall = 1'b1;
    for (int i = 0; i < 30; i++)
      send_request(MODE_ALLOC, 0, 64'($urandom_range(1, 32'h4000)), 1);
  endtask

  // Random alloc/free traffic over small and varied regions
  task automatic test_random(int n);
    logic [63:0] b, s, sa, len;
    logic [63:0] grants [$];
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin b = rand64() & 64'h0000_FFFF_FFFF_F000; s = 64'h80_0000; end
        1: begin b = rand64(); s = 64'h20_0000 + 64'({$urandom_range(0, 255), 12'h0}); end
        2: begin b = 64'h1000; s = 64'h1000; end
        default: begin b = rand64(); s = rand64() | 64'h1000; end
      endcase
      set_region(b, s);
      grants.delete();
      for (int k = 0; k < n / 4; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          len = (pick < 40) ? 64'($urandom_range(1, 32'h6000)) : rand64();
          send_request(MODE_ALLOC, rand64(), len);
          if (pending_results[$].status == ST_OK)
            grants.push_back({pending_results[$].addr[63:12], 12'h0});
        end else if (pick < 85 && grants.size() > 0) begin
          sa = grants[$urandom_range(0, grants.size() - 1)];
          send_request(MODE_FREE, sa, 64'($urandom_range(1, 32'h4000)));
        end else begin
          sa = ($urandom_range(0, 1)) ?
               (region_lo() + 64'({$urandom_range(0, 4095), 12'h0})) : rand64();
          len = ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(0, 32'h3000));
          send_request(MODE_FREE, sa, len);
        end
      end
    end
  endtask

  initial begin
    cfg_base = BASE_RST;
    cfg_size = SIZE_RST;
    reload_list();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    test_directed();
    test_saturated_region();
    test_list_full();
    test_backpressure();
    test_random(640);
    wait_idle();
    $display("Covered %0d transfers (%0d ok, %0d rejected) across directed,", results_seen,
             n_ok, n_rej);
    $display("list-full, saturated-region, back-pressure and random phases.");
    if (errors == 0) begin
      $display("** page_range_first_fit_allocator: PASSED **");
    end else begin
      $display("** page_range_first_fit_allocator: FAILED **");
    end
    $finish;
  end

endmodule
